// File: design/rational_arith_unit_assert.svh
// Assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 30;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;
endpackage
`default_nettype wire

// File: design/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rau_divider #(
    parameter int W = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg, q_reg[W-1]};
        trial     = shifted - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule
`default_nettype wire

// File: design/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit
// Fraction add, subtract, multiply and divide with GCD reduction.
// ----------------------------------------------------------------------------
// Usage: the request channel (in_valid/in_ready) carries req_type and two
// fractions; the result channel (out_valid/out_ready) carries res_num,
// res_den and div_zero. One result per request.
// A request is taken only while the block is idle. Cross products are
// formed on a single shared multiplier (three passes, two for divide),
// then the sign is handled. The GCD is a Euclid loop on a shared
// restoring divider of 2*OPERAND_WIDTH+2 bits, one quotient bit per cycle;
// each remainder step is one division, and two more divisions reduce the
// fraction. A zero denominator skips the GCD and returns div_zero with
// 0/1. The next request is taken only after the result handshake.
// Reset clears the sequencer; no request is in flight afterwards.
// A stalled receiver holds the result in the output register; no new
// request is taken until it is collected.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    req_type,
    input  wire logic signed [OPERAND_WIDTH-1:0] a_num,
    input  wire logic [OPERAND_WIDTH-2:0]      a_den,
    input  wire logic signed [OPERAND_WIDTH-1:0] b_num,
    input  wire logic [OPERAND_WIDTH-2:0]      b_den,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [rau_pkg::RES_NUM_W-1:0] res_num,
    output logic [rau_pkg::RES_DEN_W-1:0]      res_den,
    output logic                               div_zero
);
    import rau_pkg::*;

    localparam int OW = OPERAND_WIDTH;
    localparam int PW = 2 * OW + 1;
    localparam int MW = 2 * OW + 2;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_M1    = 10'b0000000010,
        S_M2    = 10'b0000000100,
        S_M3    = 10'b0000001000,
        S_PREP  = 10'b0000010000,
        S_GCD   = 10'b0000100000,
        S_DN    = 10'b0001000000,
        S_DD    = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    op_t                 op_reg;
    logic signed [OW-1:0] an_reg, bn_reg;
    logic [OW-2:0]       ad_reg, bd_reg;
    logic signed [PW-1:0] n_reg, n_next;
    logic signed [PW-1:0] d_reg, d_next;
    logic [MW-1:0]       x_reg, x_next, y_reg, y_next;
    logic [MW-1:0]       nm_reg, nm_next, dm_reg, dm_next;
    logic                neg_reg, neg_next;
    logic                pend_reg, pend_next;
    logic signed [RES_NUM_W-1:0] rn_reg, rn_next;
    logic [RES_DEN_W-1:0] rd_reg, rd_next;
    logic                dz_reg, dz_next;

    logic signed [OW:0]   mul_a, mul_b;
    logic signed [2*OW+1:0] prod;

    logic            div_start;
    logic            div_done;
    logic [MW-1:0]   div_a, div_b, div_q, div_r;

    rau_divider #(.W(MW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M1:
            begin
                mul_a = (OW+1)'(an_reg);
                mul_b = (op_reg == OP_MUL) ? (OW+1)'(bn_reg) : $signed({2'b00, bd_reg});
            end
            S_M2:
            begin
                mul_a = (OW+1)'(bn_reg);
                mul_b = $signed({2'b00, ad_reg});
            end
            S_M3:
            begin
                mul_a = $signed({2'b00, ad_reg});
                mul_b = $signed({2'b00, bd_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        nm_next    = nm_reg;
        dm_next    = dm_reg;
        neg_next   = neg_reg;
        pend_next  = 1'b0;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        dz_next    = dz_reg;
        div_start  = 1'b0;
        div_a      = x_reg;
        div_b      = y_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_M1;
                end
            end
            S_M1:
            begin
                n_next     = PW'(prod);
                state_next = S_M2;
            end
            S_M2:
            begin
                case (op_reg)
                    OP_ADD: n_next = n_reg + PW'(prod);
                    OP_SUB: n_next = n_reg - PW'(prod);
                    OP_DIV: d_next = PW'(prod);
                    default: n_next = n_reg;
                endcase
                state_next = (op_reg == OP_DIV) ? S_PREP : S_M3;
            end
            S_M3:
            begin
                d_next     = PW'(prod);
                state_next = S_PREP;
            end
            S_PREP:
            begin
                nm_next  = n_reg[PW-1] ? MW'(-n_reg) : MW'(n_reg);
                dm_next  = d_reg[PW-1] ? MW'(-d_reg) : MW'(d_reg);
                neg_next = n_reg[PW-1] ^ d_reg[PW-1];
                x_next   = nm_next;
                y_next   = dm_next;
                if (d_reg == '0)
                begin
                    rn_next    = '0;
                    rd_next    = RES_DEN_W'(1);
                    dz_next    = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    dz_next    = 1'b0;
                    state_next = S_GCD;
                    pend_next  = 1'b1;
                end
            end
            S_GCD:
            begin
                if (pend_reg)
                begin
                    if (y_reg == '0)
                    begin
                        div_a      = nm_reg;
                        div_b      = x_reg;
                        div_start  = 1'b1;
                        state_next = S_DN;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
                else if (div_done)
                begin
                    x_next    = y_reg;
                    y_next    = div_r;
                    pend_next = 1'b1;
                end
            end
            S_DN:
            begin
                if (div_done)
                begin
                    nm_next    = div_q;
                    div_a      = dm_reg;
                    div_b      = x_reg;
                    div_start  = 1'b1;
                    state_next = S_DD;
                end
            end
            S_DD:
            begin
                if (div_done)
                begin
                    dm_next    = div_q;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                rn_next    = neg_reg ? RES_NUM_W'(-nm_reg) : RES_NUM_W'(nm_reg);
                rd_next    = RES_DEN_W'(dm_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg <= op_t'(req_type);
            an_reg <= a_num;
            ad_reg <= a_den;
            bn_reg <= b_num;
            bd_reg <= b_den;
        end
        n_reg   <= n_next;
        d_reg   <= d_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        nm_reg  <= nm_next;
        dm_reg  <= dm_next;
        neg_reg <= neg_next;
        rn_reg  <= rn_next;
        rd_reg  <= rd_next;
        dz_reg  <= dz_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign res_num   = rn_reg;
    assign res_den   = rd_reg;
    assign div_zero  = dz_reg;
endmodule
`default_nettype wire

// File: design/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arith_unit_assert.svh"
module rau_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [29:0] res_den,
    input wire logic [31:0] res_num,
    input wire logic        div_zero
);
    `RAU_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
    `RAU_ASSERT_IMP(a_den_pos, clk, rst_n, out_valid, res_den != 30'd0)
    `RAU_ASSERT_IMP(a_dz_form, clk, rst_n, out_valid && div_zero,
        res_num == 32'd0 && res_den == 30'd1)
    `RAU_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)
endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_den   (res_den),
    .res_num   (res_num),
    .div_zero  (div_zero)
);
`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rational arithmetic unit. Directed fractions,
// then random requests with and without random idling on both channels,
// a long result hold-off and a drain pause. Every result is compared field
// by field with an in-bench prediction of the reduced fraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import rau_pkg::*;

    localparam int OW = OPERAND_WIDTH_DEF;

    typedef struct {
        logic signed [RES_NUM_W-1:0] num;
        logic [RES_DEN_W-1:0]        den;
        logic                        dz;
    } fraction_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           req_type;
    logic signed [OW-1:0] a_num;
    logic [OW-2:0]        a_den;
    logic signed [OW-1:0] b_num;
    logic [OW-2:0]        b_den;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0] res_den;
    logic                 div_zero;

    fraction_t expected_fracs[$];
    int  n_requests = 0;
    int  n_results = 0;
    int  n_div_zero = 0;
    int  n_errors = 0;
    bit  send_idle_en = 1'b1;
    bit  recv_idle_en = 1'b1;
    int  recv_hold = 0;

    rational_arith_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .res_num  (res_num),
        .res_den  (res_den),
        .div_zero (div_zero)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic fraction_t reduce_fraction(input op_t op,
                                                  input logic signed [OW-1:0] an,
                                                  input logic [OW-2:0] ad,
                                                  input logic signed [OW-1:0] bn,
                                                  input logic [OW-2:0] bd);
        longint san;
        longint sbn;
        longint sad;
        longint sbd;
        longint n;
        longint d;
        longint unsigned nm;
        longint unsigned dm;
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        longint unsigned rn;
        bit nneg;
        bit dneg;
        fraction_t f;
        san = an;
        sbn = bn;
        sad = ad;
        sbd = bd;
        case (op)
            OP_ADD:  begin n = san * sbd + sbn * sad; d = sad * sbd; end
            OP_SUB:  begin n = san * sbd - sbn * sad; d = sad * sbd; end
            OP_MUL:  begin n = san * sbn; d = sad * sbd; end
            default: begin n = san * sbd; d = sad * sbn; end
        endcase
        nneg = (n < 0);
        dneg = (d < 0);
        nm = nneg ? -n : n;
        dm = dneg ? -d : d;
        if (dm == 0)
        begin
            f.num = '0;
            f.den = RES_DEN_W'(1);
            f.dz = 1'b1;
            return f;
        end
        x = nm;
        y = dm;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        nm = nm / x;
        dm = dm / x;
        rn = (nneg != dneg) ? -nm : nm;
        f.num = rn[RES_NUM_W-1:0];
        f.den = dm[RES_DEN_W-1:0];
        f.dz = 1'b0;
        return f;
    endfunction

    // valid stays high after acceptance; the next call reuses or lowers it
    task automatic send_request(input op_t op, input logic signed [OW-1:0] an,
                                input logic [OW-2:0] ad,
                                input logic signed [OW-1:0] bn,
                                input logic [OW-2:0] bd);
        int gap;
        gap = 0;
        if (send_idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        do
            @(negedge clk);
        while (!in_ready);
        expected_fracs.push_back(reduce_fraction(op, an, ad, bn, bd));
        n_requests++;
        @(posedge clk);
    endtask

    task automatic lower_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_fracs.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [OW-2:0] rand_den();
        int r;
        r = $urandom_range(0, 39);
        if (r == 0)
            return '0;
        if (r < 12)
            return (OW-1)'($urandom_range(1, 40));
        return (OW-1)'($urandom_range(1, 32767));
    endfunction

    function automatic logic signed [OW-1:0] rand_num();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r < 7)
            return OW'($signed(OW'($urandom_range(0, 80))) - 40);
        return OW'($urandom);
    endfunction

    task automatic send_random();
        send_request(op_t'($urandom_range(0, 3)), rand_num(), rand_den(),
                     rand_num(), rand_den());
    endtask

    task automatic test_directed();
        send_request(OP_ADD, 16'sd1, 15'd2, 16'sd1, 15'd3);
        send_request(OP_SUB, 16'sd1, 15'd2, 16'sd1, 15'd2);
        send_request(OP_MUL, -16'sd3, 15'd4, 16'sd8, 15'd9);
        send_request(OP_DIV, 16'sd5, 15'd7, -16'sd10, 15'd21);
        send_request(OP_DIV, 16'sd5, 15'd7, 16'sd0, 15'd3);
        send_request(OP_DIV, -16'sd32768, 15'd1, 16'sd0, 15'd32767);
        send_request(OP_ADD, 16'sd0, 15'd5, 16'sd0, 15'd9);
        send_request(OP_MUL, 16'sd0, 15'd32767, 16'sd123, 15'd1);
        send_request(OP_ADD, 16'sd3, 15'd0, 16'sd4, 15'd5);
        send_request(OP_MUL, 16'sd3, 15'd5, 16'sd4, 15'd0);
        send_request(OP_DIV, 16'sd3, 15'd0, 16'sd4, 15'd5);
        send_request(OP_SUB, 16'sd1, 15'd0, 16'sd1, 15'd0);
        send_request(OP_ADD, 16'sd32767, 15'd1, 16'sd32767, 15'd1);
        send_request(OP_SUB, -16'sd32768, 15'd1, 16'sd32767, 15'd1);
        send_request(OP_MUL, -16'sd32768, 15'd1, -16'sd32768, 15'd1);
        send_request(OP_DIV, -16'sd32768, 15'd32767, -16'sd1, 15'd32767);
        send_request(OP_ADD, 16'sd32767, 15'd32767, -16'sd32768, 15'd32766);
        send_request(OP_MUL, 16'sd32767, 15'd32767, 16'sd32767, 15'd32767);
        send_request(OP_DIV, 16'sd1, 15'd32767, 16'sd32767, 15'd1);
        send_request(OP_SUB, -16'sd1, 15'd16384, 16'sd1, 15'd16383);
        send_request(OP_DIV, -16'sd6, 15'd4, -16'sd9, 15'd6);
        lower_valid();
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random();
        lower_valid();
    endtask

    task automatic test_result_backpressure();
        recv_hold = 400;
        repeat (6) send_random();
        lower_valid();
    endtask

    task automatic test_drain_pause();
        repeat (20) send_random();
        lower_valid();
        wait_drained();
        repeat (20) send_random();
        lower_valid();
    endtask

    task automatic test_no_idle(input int count);
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        repeat (count) send_random();
        lower_valid();
    endtask

    initial
    begin
        int burst;
        bit rdy;
        burst = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rdy = 1'b1;
            if (recv_hold > 0)
            begin
                recv_hold--;
                rdy = 1'b0;
            end
            else
            begin
                if (recv_idle_en && burst == 0 && $urandom_range(0, 5) == 0)
                    burst = $urandom_range(1, 13);
                if (burst > 0)
                begin
                    burst--;
                    rdy = 1'b0;
                end
            end
            out_ready <= rdy;
        end
    end

    initial
    begin
        fraction_t exp_f;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                n_results++;
                if (expected_fracs.size() == 0)
                begin
                    $display("%0t unexpected result %0d/%0d dz %0b", $time, res_num,
                             res_den, div_zero);
                    n_errors++;
                end
                else
                begin
                    exp_f = expected_fracs.pop_front();
                    if (exp_f.dz)
                        n_div_zero++;
                    if (res_num !== exp_f.num)
                    begin
                        $display("%0t res_num expected %0d actual %0d", $time,
                                 exp_f.num, res_num);
                        n_errors++;
                    end
                    if (res_den !== exp_f.den)
                    begin
                        $display("%0t res_den expected %0d actual %0d", $time,
                                 exp_f.den, res_den);
                        n_errors++;
                    end
                    if (div_zero !== exp_f.dz)
                    begin
                        $display("%0t div_zero expected %0b actual %0b", $time,
                                 exp_f.dz, div_zero);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        #200_000_000;
        $display("timeout with %0d results outstanding", expected_fracs.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        req_type <= '0;
        a_num <= '0;
        a_den <= '0;
        b_num <= '0;
        b_den <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(400);
        test_result_backpressure();
        test_drain_pause();
        test_random(400);
        test_no_idle(150);

        wait_drained();
        repeat (100) @(posedge clk);
        if (expected_fracs.size() != 0)
            n_errors++;
        $display("requests %0d, results %0d, divide-by-zero results %0d", n_requests,
                 n_results, n_div_zero);
        $display("all four operations, zero and extreme operands, stalls on both sides");
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
